// ----- rtl/key_scan_debounce_long_press_unit_defines.svh -----
// Assertion macros for the key scan debounce and long press unit.
`ifndef KEY_SCAN_DEBOUNCE_LONG_PRESS_UNIT_DEFINES_SVH
`define KEY_SCAN_DEBOUNCE_LONG_PRESS_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define KSLP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define KSLP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/kslp_pkg.sv -----
// Shared types and constants for the key scan debounce and long press unit.
package kslp_pkg;

  localparam int NUM_KEYS_DEF   = 7;
  localparam int KEY_INPUT_BITS = 7;
  localparam int KEY_IDX_W      = 3;
  localparam int IDX_EXT_W      = 4;
  localparam int CNT_W          = 8;
  localparam int CFG_IDX_W      = 2;

  localparam logic [CNT_W-1:0] TALLY_CAP = 8'd250;

  localparam logic [CNT_W-1:0] PRESS_TICKS_RST  = 8'd3;
  localparam logic [CNT_W-1:0] LONG_TICKS_RST   = 8'd50;
  localparam logic [CNT_W-1:0] REPEAT_COUNT_RST = 8'd1;

  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_TICKS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_TICKS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_COUNT = 2'd2;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_RELEASE = 2'd1,
    EV_PRESS   = 2'd2,
    EV_LONG    = 2'd3
  } kslp_event_t;

  typedef struct packed {
    logic [CNT_W-1:0] press_ticks;
    logic [CNT_W-1:0] long_ticks;
    logic [CNT_W-1:0] repeat_count;
  } kslp_cfg_t;

  typedef struct packed {
    logic [KEY_IDX_W-1:0] key_index;
    kslp_event_t          event_kind;
  } kslp_result_t;

endpackage

// ----- rtl/kslp_key_update.sv -----
// Next hold count, repeat tally and event for the key under scan.
module kslp_key_update (
  input  logic                        key_pressed,
  input  logic [kslp_pkg::CNT_W-1:0]  hold_cnt,
  input  logic [kslp_pkg::CNT_W-1:0]  tally,
  input  kslp_pkg::kslp_cfg_t         cfg,
  output logic [kslp_pkg::CNT_W-1:0]  hold_cnt_nxt,
  output logic [kslp_pkg::CNT_W-1:0]  tally_nxt,
  output kslp_pkg::kslp_event_t       event_kind
);

  logic [kslp_pkg::CNT_W-1:0] cnt_inc;
  logic [kslp_pkg::CNT_W-1:0] cnt_dec;
  logic [kslp_pkg::CNT_W-1:0] t_work;

  assign cnt_inc = kslp_pkg::CNT_W'(hold_cnt + 8'd1);
  assign cnt_dec = kslp_pkg::CNT_W'(hold_cnt - 8'd1);

  always_comb begin
    hold_cnt_nxt = hold_cnt;
    t_work       = tally;
    event_kind   = kslp_pkg::EV_NONE;
    if (key_pressed) begin
      hold_cnt_nxt = cnt_inc;
      if (cnt_inc >= cfg.press_ticks) begin
        if (cnt_inc == cfg.press_ticks) begin
          t_work     = '0;
          event_kind = kslp_pkg::EV_PRESS;
        end
        // long step: bump the saturating tally, fall back to the press count
        if (cnt_inc == cfg.long_ticks) begin
          if (t_work < kslp_pkg::TALLY_CAP) begin
            t_work = kslp_pkg::CNT_W'(t_work + 8'd1);
          end
          if (t_work >= cfg.repeat_count) begin
            event_kind = kslp_pkg::EV_LONG;
            t_work     = '0;
          end
          hold_cnt_nxt = cfg.press_ticks;
        end
      end
    end else if (hold_cnt != '0) begin
      // clamp a long hold first, then count down to the release
      if (hold_cnt > cfg.press_ticks) begin
        hold_cnt_nxt = cfg.press_ticks;
      end else begin
        hold_cnt_nxt = cnt_dec;
        if (cnt_dec == '0) begin
          event_kind = kslp_pkg::EV_RELEASE;
        end
      end
    end
    tally_nxt = t_work;
  end

endmodule

// ----- rtl/kslp_key_bank.sv -----
// Per-key hold counters, repeat tallies and the round-robin scan index.
module kslp_key_bank #(
  parameter int NUM_KEYS = kslp_pkg::NUM_KEYS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                step,
  input  logic [kslp_pkg::KEY_INPUT_BITS-1:0] keys_down,
  input  kslp_pkg::kslp_cfg_t                 cfg,
  output kslp_pkg::kslp_result_t              result
);

  localparam int IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  logic [kslp_pkg::CNT_W-1:0] hold_count_r [NUM_KEYS];
  logic [kslp_pkg::CNT_W-1:0] tally_r      [NUM_KEYS];
  logic [IDX_W-1:0]           scan_idx_r;
  logic [IDX_W-1:0]           scan_idx_nxt;

  logic [kslp_pkg::IDX_EXT_W-1:0]    idx_ext;
  logic [kslp_pkg::KEY_INPUT_BITS:0] keys_pad;
  logic                              key_pressed;
  logic [kslp_pkg::CNT_W-1:0]        hold_nxt;
  logic [kslp_pkg::CNT_W-1:0]        tally_nxt;
  kslp_pkg::kslp_event_t             event_kind;

  assign idx_ext  = kslp_pkg::IDX_EXT_W'(scan_idx_r);
  assign keys_pad = {1'b0, keys_down};

  // keys past the input mask read as released
  assign key_pressed = (idx_ext < kslp_pkg::IDX_EXT_W'(kslp_pkg::KEY_INPUT_BITS))
                       && keys_pad[idx_ext[kslp_pkg::KEY_IDX_W-1:0]];

  assign scan_idx_nxt = (scan_idx_r == IDX_W'(NUM_KEYS - 1)) ? '0
                        : IDX_W'(scan_idx_r + 1'b1);

  kslp_key_update u_update (
    .key_pressed  (key_pressed),
    .hold_cnt     (hold_count_r[scan_idx_r]),
    .tally        (tally_r[scan_idx_r]),
    .cfg          (cfg),
    .hold_cnt_nxt (hold_nxt),
    .tally_nxt    (tally_nxt),
    .event_kind   (event_kind)
  );

  always_comb begin
    result.key_index  = idx_ext[kslp_pkg::KEY_IDX_W-1:0];
    result.event_kind = event_kind;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        hold_count_r[k] <= '0;
        tally_r[k]      <= '0;
      end
      scan_idx_r <= '0;
    end else if (step) begin
      hold_count_r[scan_idx_r] <= hold_nxt;
      tally_r[scan_idx_r]      <= tally_nxt;
      scan_idx_r               <= scan_idx_nxt;
    end
  end

endmodule

// ----- rtl/key_scan_debounce_long_press_unit.sv -----
// Key scan debounce and long press unit: input register, key update, result register.
// An accepted input beat passes through the input register, then the result register.
// Throughput: one beat per cycle while out_ready is high; the key state is read and
//   written in the same cycle that the beat moves on to the result register.
// Reset (synchronous, rst_n low): counters, tallies and scan index clear, the
//   registers return to press 3, long 50, repeat 1, and both stages empty.
`include "key_scan_debounce_long_press_unit_defines.svh"

module key_scan_debounce_long_press_unit #(
  parameter int NUM_KEYS = kslp_pkg::NUM_KEYS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [kslp_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [kslp_pkg::CNT_W-1:0]             cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [kslp_pkg::KEY_INPUT_BITS-1:0]    in_keys_down,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [kslp_pkg::KEY_IDX_W-1:0]         out_key_index,
  output logic [1:0]                             out_event_kind
);

  kslp_pkg::kslp_cfg_t cfg_r;

  logic                                s1_valid_r;
  logic                                s1_valid_nxt;
  logic [kslp_pkg::KEY_INPUT_BITS-1:0] s1_keys_r;
  logic                                s1_move;
  logic                                out_free;
  logic                                out_valid_r;
  logic                                out_valid_nxt;
  kslp_pkg::kslp_result_t              result;
  kslp_pkg::kslp_result_t              out_result_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.press_ticks  <= kslp_pkg::PRESS_TICKS_RST;
      cfg_r.long_ticks   <= kslp_pkg::LONG_TICKS_RST;
      cfg_r.repeat_count <= kslp_pkg::REPEAT_COUNT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        kslp_pkg::CFG_PRESS_TICKS:  cfg_r.press_ticks  <= cfg_data;
        kslp_pkg::CFG_LONG_TICKS:   cfg_r.long_ticks   <= cfg_data;
        kslp_pkg::CFG_REPEAT_COUNT: cfg_r.repeat_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // hand the input beat on whenever the result register is free or draining
  assign out_free      = !out_valid_r || out_ready;
  assign s1_move       = s1_valid_r && out_free;
  assign in_ready      = !s1_valid_r || s1_move;
  assign s1_valid_nxt  = (in_valid && in_ready) || (s1_valid_r && !s1_move);
  assign out_valid_nxt = s1_move || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_keys_r <= in_keys_down;
    end
    if (s1_move) begin
      out_result_r <= result;
    end
  end

  kslp_key_bank #(
    .NUM_KEYS (NUM_KEYS)
  ) u_bank (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_move),
    .keys_down (s1_keys_r),
    .cfg       (cfg_r),
    .result    (result)
  );

  assign out_valid      = out_valid_r;
  assign out_key_index  = out_result_r.key_index;
  assign out_event_kind = out_result_r.event_kind;

  `KSLP_ASSERT_NEXT(a_move_fills_out, s1_move, out_valid_r, "scanned beat did not reach the result register")
  `KSLP_ASSERT_NOW(a_empty_stage_ready, !s1_valid_r, in_ready, "input register empty but not ready")
  `KSLP_ASSERT_NEXT(a_stalled_stage_holds, s1_valid_r && !s1_move, s1_valid_r && $stable(s1_keys_r), "stalled input register lost its beat")

endmodule
